// File: src/nrgp_pkg.sv
// ============================================================================
// nrgp_pkg: NMEA RMC/GGA sentence parser shared types and constants
// Holds the record layout, the job passed from parser to formatter and the
// constants that both sides use.
// ============================================================================
package nrgp_pkg;

  localparam int unsigned DecWidth = 27;
  localparam logic [DecWidth-1:0] DecMax = 27'd99999999;
  localparam logic [4:0] ZoneReset = 5'd8;
  localparam int unsigned QueueDepth = 2;

  localparam logic [7:0] ChDollar = 8'h24;
  localparam logic [7:0] ChComma  = 8'h2C;
  localparam logic [7:0] ChPoint  = 8'h2E;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChNine   = 8'h39;
  localparam logic [7:0] ChA      = 8'h41;
  localparam logic [7:0] ChC      = 8'h43;
  localparam logic [7:0] ChE      = 8'h45;
  localparam logic [7:0] ChN      = 8'h4E;

  typedef enum logic {
    REC_RMC = 1'b0,
    REC_GGA = 1'b1
  } rec_type_t;

  // Raw sentence content handed from the parser to the formatter.
  typedef struct packed {
    rec_type_t            kind;
    logic [1:0]           hemi;
    logic [DecWidth-1:0]  lat;
    logic [DecWidth-1:0]  lon;
    logic [DecWidth-1:0]  speed;
    logic [DecWidth-1:0]  course;
    logic [DecWidth-1:0]  sea;
    logic [DecWidth-1:0]  ground;
    logic [5:0][3:0]      tdig;
    logic [5:0][3:0]      ddig;
  } job_t;

  typedef struct packed {
    logic        record_type;
    logic        is_north;
    logic        is_east;
    logic [18:0] lat_dms;
    logic [19:0] lon_dms;
    logic [27:0] speed_kmh_milli;
    logic [26:0] course_milli;
    logic [26:0] sea_height_milli;
    logic [26:0] ground_height_milli;
    logic [15:0] date_packed;
    logic [16:0] time_packed;
  } rec_t;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       end_of_sentence;
  } in_t;

  function automatic logic [3:0] digit_or_zero(input logic [7:0] c);
    logic [7:0] d;
    d = c - ChZero;
    return (c >= ChZero && c <= ChNine) ? d[3:0] : 4'd0;
  endfunction

endpackage

// File: src/nrgp_if.sv
// ============================================================================
// nrgp_stream_if: valid/ready channel
// Carries one payload of a chosen type between a source and a sink.
// ============================================================================
interface nrgp_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// File: src/nrgp_parser.sv
// ============================================================================
// nrgp_parser: byte front end
// Tracks position, commas and field values of the sentence and, on its final
// byte, pushes one job for the formatter when a record is due.
// ============================================================================
module nrgp_parser
  import nrgp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_fire,
  input  in_t      in_item,
  output logic     job_push,
  output job_t     job
);

  logic [6:0]          pos_r;
  logic [3:0]          commas_r;
  logic [7:0]          type_r;
  logic                fix_r;
  logic [DecWidth-1:0] acc_r;
  logic [2:0]          frac_r;
  logic [DecWidth-1:0] saved_r [6];
  logic [1:0]          hemi_r;
  logic [5:0][3:0]     tdig_r;
  logic [5:0][3:0]     ddig_r;
  logic [2:0]          fchars_r;

  logic [7:0]          c;
  logic                clr;
  logic [6:0]          pos;
  logic [3:0]          commas;
  logic [7:0]          typ;
  logic                fix;
  logic [DecWidth-1:0] acc;
  logic [2:0]          frac;
  logic [1:0]          hemi;
  logic [5:0][3:0]     tdig;
  logic [5:0][3:0]     ddig;
  logic [2:0]          fchars;
  logic [DecWidth-1:0] saved [6];
  logic [DecWidth-1:0] sv_c [6];
  logic [3:0]          dig;
  logic [34:0]         prod;
  logic                is_digit;
  logic [2:0]          slot;

  logic [6:0]          pos_nxt;
  logic [3:0]          commas_nxt;
  logic [7:0]          type_nxt;
  logic                fix_nxt;
  logic [DecWidth-1:0] acc_nxt;
  logic [2:0]          frac_nxt;
  logic [1:0]          hemi_nxt;
  logic [5:0][3:0]     tdig_nxt;
  logic [5:0][3:0]     ddig_nxt;
  logic [2:0]          fchars_nxt;
  logic [DecWidth-1:0] saved_nxt [6];

  function automatic logic [2:0] slot_of(input logic [7:0] t, input logic [3:0] n);
    logic [2:0] s;
    s = 3'd7;
    if (t == ChC) begin
      case (n)
        4'd3: s = 3'd0;
        4'd5: s = 3'd1;
        4'd7: s = 3'd2;
        4'd8: s = 3'd3;
        default: s = 3'd7;
      endcase
    end else if (t == ChA) begin
      case (n)
        4'd9:  s = 3'd4;
        4'd11: s = 3'd5;
        default: s = 3'd7;
      endcase
    end
    return s;
  endfunction

  always_comb begin
    c   = in_item.char_byte;
    clr = (c == ChDollar);
    pos    = clr ? '0 : pos_r;
    commas = clr ? '0 : commas_r;
    typ    = clr ? '0 : type_r;
    fix    = clr ? 1'b0 : fix_r;
    acc    = clr ? '0 : acc_r;
    frac   = clr ? '0 : frac_r;
    hemi   = clr ? '0 : hemi_r;
    tdig   = clr ? '0 : tdig_r;
    ddig   = clr ? '0 : ddig_r;
    fchars = clr ? '0 : fchars_r;
    for (int i = 0; i < 6; i++) begin
      saved[i] = clr ? '0 : saved_r[i];
    end

    if (pos == 7'd5) typ = c;
    if (pos >= 7'd7 && pos <= 7'd12) tdig[3'(pos - 7'd7)] = digit_or_zero(c);

    dig      = digit_or_zero(c);
    is_digit = (c >= ChZero && c <= ChNine);
    prod     = '0;

    if (c == ChComma) begin
      slot = slot_of(typ, commas);
      if (slot != 3'd7) saved[slot] = acc;
      if (commas != 4'd15) commas = commas + 4'd1;
      acc    = '0;
      frac   = '0;
      fchars = '0;
    end else begin
      slot = 3'd7;
      if (fchars == '0) begin
        if (commas == 4'd2) fix = (c == ChA);
        else if (commas == 4'd4) hemi[0] = (c == ChN);
        else if (commas == 4'd6) hemi[1] = (c == ChE);
      end
      if (typ == ChC && commas == 4'd9 && fchars < 3'd6) ddig[fchars] = dig;
      if (c == ChPoint) begin
        if (frac == '0) frac = 3'd1;
      end else if (is_digit) begin
        // Integer digits shift the value; fraction digits add at their weight.
        if (frac == '0) begin
          prod = 35'(acc) * 35'd10 + 35'(dig) * 35'd1000;
          acc  = (prod > 35'(DecMax)) ? DecMax : prod[DecWidth-1:0];
        end else if (frac < 3'd4) begin
          case (frac)
            3'd1:    prod = 35'(acc) + 35'(dig) * 35'd100;
            3'd2:    prod = 35'(acc) + 35'(dig) * 35'd10;
            default: prod = 35'(acc) + 35'(dig);
          endcase
          acc  = (prod > 35'(DecMax)) ? DecMax : prod[DecWidth-1:0];
          frac = frac + 3'd1;
        end
      end
      if (fchars != 3'd7) fchars = fchars + 3'd1;
    end
    if (pos != 7'd127) pos = pos + 7'd1;

    // Final byte commits the open field without bumping the comma count.
    for (int i = 0; i < 6; i++) sv_c[i] = saved[i];
    if (slot_of(typ, commas) != 3'd7) sv_c[slot_of(typ, commas)] = acc;

    job.kind   = (typ == ChA) ? REC_GGA : REC_RMC;
    job.hemi   = hemi;
    job.lat    = sv_c[0];
    job.lon    = sv_c[1];
    job.speed  = sv_c[2];
    job.course = sv_c[3];
    job.sea    = sv_c[4];
    job.ground = sv_c[5];
    job.tdig   = tdig;
    job.ddig   = ddig;
    job_push   = in_fire && in_item.end_of_sentence &&
                 ((typ == ChC && fix) || typ == ChA);

    if (in_item.end_of_sentence) begin
      pos_nxt = '0; commas_nxt = '0; type_nxt = '0; fix_nxt = 1'b0;
      acc_nxt = '0; frac_nxt = '0; hemi_nxt = '0; tdig_nxt = '0;
      ddig_nxt = '0; fchars_nxt = '0;
      for (int i = 0; i < 6; i++) saved_nxt[i] = '0;
    end else begin
      pos_nxt = pos; commas_nxt = commas; type_nxt = typ; fix_nxt = fix;
      acc_nxt = acc; frac_nxt = frac; hemi_nxt = hemi; tdig_nxt = tdig;
      ddig_nxt = ddig; fchars_nxt = fchars;
      for (int i = 0; i < 6; i++) saved_nxt[i] = saved[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0; commas_r <= '0; type_r <= '0; fix_r <= 1'b0;
      acc_r <= '0; frac_r <= '0; hemi_r <= '0; tdig_r <= '0;
      ddig_r <= '0; fchars_r <= '0;
      for (int i = 0; i < 6; i++) saved_r[i] <= '0;
    end else if (in_fire) begin
      pos_r <= pos_nxt; commas_r <= commas_nxt; type_r <= type_nxt;
      fix_r <= fix_nxt; acc_r <= acc_nxt; frac_r <= frac_nxt;
      hemi_r <= hemi_nxt; tdig_r <= tdig_nxt; ddig_r <= ddig_nxt;
      fchars_r <= fchars_nxt;
      for (int i = 0; i < 6; i++) saved_r[i] <= saved_nxt[i];
    end
  end

endmodule

// File: src/nrgp_queue.sv
// ============================================================================
// nrgp_queue: job queue
// Small register FIFO between the parser and the formatter.
// ============================================================================
module nrgp_queue
  import nrgp_pkg::*;
#(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_data,
  output logic full,
  output logic empty,
  input  logic pop,
  output job_t pop_data
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  job_t                mem_r [Depth];
  logic [AW-1:0]       wr_r, rd_r;
  logic [AW:0]         cnt_r;

  assign full     = (cnt_r == (AW+1)'(Depth));
  assign empty    = (cnt_r == '0);
  assign pop_data = mem_r[rd_r];

  function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
    return (p == AW'(Depth - 1)) ? '0 : p + AW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r <= '0; rd_r <= '0; cnt_r <= '0;
    end else begin
      if (push) wr_r <= bump(wr_r);
      if (pop)  rd_r <= bump(rd_r);
      cnt_r <= cnt_r + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

endmodule

// File: src/nrgp_formatter.sv
// ============================================================================
// nrgp_formatter: record back end
// Converts one job into a record over four stages: digits to numbers and
// the degree split, the clock rollover with the minute split, the day/month
// rollover with the second split, then packing.
// ============================================================================
module nrgp_formatter
  import nrgp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic [4:0] zone,
  input  logic       job_valid,
  input  job_t       job,
  output logic       job_pop,
  output logic       rec_valid,
  input  logic       rec_ready,
  output rec_t       rec
);

  typedef struct packed {
    rec_type_t  kind;
    logic [1:0] hemi;
    logic [7:0] lat_deg, lon_deg;
    logic [16:0] lat_mm, lon_mm;
    logic [5:0] lat_min, lon_min;
    logic [9:0] lat_fr, lon_fr;
    logic [5:0] lat_sec, lon_sec;
    logic [29:0] spd_q;
    logic [27:0] spd_kmh;
    logic [DecWidth-1:0] course, sea, ground;
    logic [6:0] hour, minute, second, day, month, yy;
  } s1_t;

  logic  v1_r, v2_r, v3_r, v4_r;
  s1_t   s1_r, s2_r, s3_r;
  rec_t  out_r;
  logic  adv4, adv3, adv2, adv1;
  s1_t   s1_nxt, s2_nxt, s3_nxt;
  rec_t  out_nxt;

  // Pipeline moves when the stage ahead is empty or moving.
  assign adv4    = !v4_r || rec_ready;
  assign adv3    = !v3_r || adv4;
  assign adv2    = !v2_r || adv3;
  assign adv1    = !v1_r || adv2;
  assign job_pop = job_valid && adv1;
  assign rec_valid = v4_r;
  assign rec       = out_r;

  // Whole degrees of a milli value below 2^27: (m >> 5) / 3125 by reciprocal.
  function automatic logic [9:0] div100k(input logic [DecWidth-1:0] m);
    logic [44:0] p;
    p = 45'(m[26:5]) * 45'd5497559;
    return p[43:34];
  endfunction

  // Saturated degrees and the remainder below one degree.
  function automatic logic [24:0] split_deg(input logic [DecWidth-1:0] m,
                                            input logic [7:0] maxd);
    logic [9:0]  d;
    logic [16:0] mm;
    logic [7:0]  ds;
    d  = div100k(m);
    mm = 17'(m - 27'(d) * 27'd100000);
    ds = (d > 10'(maxd)) ? maxd : d[7:0];
    return {ds, mm};
  endfunction

  // Saturated minutes and the thousandths of a minute, (mm >> 3) / 125.
  function automatic logic [15:0] split_min(input logic [16:0] mm);
    logic [13:0] y;
    logic [28:0] p;
    logic [6:0]  mi;
    logic [9:0]  fr;
    logic [5:0]  ms;
    y  = mm[16:3];
    p  = 29'(y) * 29'd16778;
    mi = p[27:21];
    fr = 10'(mm - 17'(mi) * 17'd1000);
    ms = (mi > 7'd59) ? 6'd59 : mi[5:0];
    return {ms, fr};
  endfunction

  // Whole seconds of a minute fraction: fr * 60 / 1000 = ((fr * 3) >> 1) / 25.
  function automatic logic [5:0] sec_of(input logic [9:0] fr);
    logic [11:0] t;
    logic [10:0] z;
    logic [22:0] p;
    t = 12'(fr) * 12'd3;
    z = t[11:1];
    p = 23'(z) * 23'd2622;
    return p[21:16];
  endfunction

  always_comb begin
    logic [24:0] a, b;
    logic [31:0] s37;
    a = split_deg(job.lat, 8'd90);
    b = split_deg(job.lon, 8'd180);
    // Speed times 1.85 is speed * 37 / 20; the divide by 5 follows next stage.
    s37 = 32'(job.speed) * 32'd37;
    s1_nxt = '0;
    s1_nxt.kind = job.kind;
    s1_nxt.hemi = job.hemi;
    s1_nxt.lat_deg = a[24:17]; s1_nxt.lat_mm = a[16:0];
    s1_nxt.lon_deg = b[24:17]; s1_nxt.lon_mm = b[16:0];
    s1_nxt.spd_q  = s37[31:2];
    s1_nxt.course = job.course;
    s1_nxt.sea    = job.sea;
    s1_nxt.ground = job.ground;
    s1_nxt.hour   = 7'(job.tdig[0]) * 7'd10 + 7'(job.tdig[1]);
    s1_nxt.minute = 7'(job.tdig[2]) * 7'd10 + 7'(job.tdig[3]);
    s1_nxt.second = 7'(job.tdig[4]) * 7'd10 + 7'(job.tdig[5]);
    s1_nxt.day    = 7'(job.ddig[0]) * 7'd10 + 7'(job.ddig[1]);
    s1_nxt.month  = 7'(job.ddig[2]) * 7'd10 + 7'(job.ddig[3]);
    s1_nxt.yy     = 7'(job.ddig[4]) * 7'd10 + 7'(job.ddig[5]);
  end

  // Stage 2: minute split and speed divide, extra second, then zone offset.
  always_comb begin
    logic [15:0] la, lo;
    logic [59:0] sp;
    s2_nxt = s1_r;
    la = split_min(s1_r.lat_mm);
    lo = split_min(s1_r.lon_mm);
    s2_nxt.lat_min = la[15:10]; s2_nxt.lat_fr = la[9:0];
    s2_nxt.lon_min = lo[15:10]; s2_nxt.lon_fr = lo[9:0];
    sp = 60'(s1_r.spd_q) * 60'd858993460;
    s2_nxt.spd_kmh = sp[59:32];
    s2_nxt.second = s1_r.second + 7'd1;
    if (s2_nxt.second > 7'd59) begin
      s2_nxt.second = '0;
      s2_nxt.minute = s1_r.minute + 7'd1;
      if (s2_nxt.minute > 7'd59) begin
        s2_nxt.minute = '0;
        s2_nxt.hour = s1_r.hour + 7'd1;
      end
    end
    s2_nxt.hour = s2_nxt.hour + 7'(zone);
  end

  // Stage 3: second split, day and month rollover, then saturation.
  always_comb begin
    logic short_m;
    s3_nxt = s2_r;
    s3_nxt.lat_sec = sec_of(s2_r.lat_fr);
    s3_nxt.lon_sec = sec_of(s2_r.lon_fr);
    short_m = (s2_r.month == 7'd2) || (s2_r.month == 7'd4) || (s2_r.month == 7'd6) ||
              (s2_r.month == 7'd9) || (s2_r.month == 7'd11);
    if (s2_r.hour > 7'd23) begin
      s3_nxt.hour = s2_r.hour - 7'd24;
      s3_nxt.day  = s2_r.day + 7'd1;
      if (s3_nxt.day > (short_m ? 7'd30 : 7'd31)) begin
        s3_nxt.day = 7'd1; s3_nxt.month = s3_nxt.month + 7'd1;
      end
      if (s3_nxt.month == 7'd2 &&
          s3_nxt.day > ((s2_r.yy[1:0] == 2'd0) ? 7'd29 : 7'd28)) begin
        s3_nxt.day = 7'd1; s3_nxt.month = 7'd3;
      end
      if (s3_nxt.month > 7'd12) begin
        s3_nxt.month = s3_nxt.month - 7'd12;
        s3_nxt.yy = s3_nxt.yy + 7'd1;
      end
    end
    if (s3_nxt.minute > 7'd59) s3_nxt.minute = 7'd59;
    if (s3_nxt.hour > 7'd23)   s3_nxt.hour   = 7'd23;
    if (s3_nxt.day > 7'd31)    s3_nxt.day    = 7'd31;
    if (s3_nxt.month > 7'd12)  s3_nxt.month  = 7'd12;
  end

  // Stage 4: pack the record.
  always_comb begin
    logic [35:0] hd;
    hd = '0;
    out_nxt = '0;
    out_nxt.record_type = s3_r.kind;
    if (s3_r.kind == REC_GGA) begin
      out_nxt.sea_height_milli    = s3_r.sea;
      out_nxt.ground_height_milli = s3_r.ground;
    end else begin
      out_nxt.is_north = s3_r.hemi[0];
      out_nxt.is_east  = s3_r.hemi[1];
      out_nxt.lat_dms  = 19'({11'(s3_r.lat_deg), 12'd0} + {s3_r.lat_min, 6'd0} + 23'(s3_r.lat_sec));
      out_nxt.lon_dms  = 20'({12'(s3_r.lon_deg), 12'd0} + {s3_r.lon_min, 6'd0} + 24'(s3_r.lon_sec));
      out_nxt.speed_kmh_milli = s3_r.spd_kmh;
      out_nxt.course_milli = s3_r.course;
      hd = 36'(s3_r.yy) * 36'd512 + 36'(s3_r.month) * 36'd32 + 36'(s3_r.day);
      out_nxt.date_packed = hd[15:0];
      hd = 36'(s3_r.hour) * 36'd4096 + 36'(s3_r.minute) * 36'd64 + 36'(s3_r.second);
      out_nxt.time_packed = hd[16:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) s1_r <= s1_nxt;
    if (adv2) s2_r <= s2_nxt;
    if (adv3) s3_r <= s3_nxt;
    if (adv4) out_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0; v4_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= job_pop;
      if (adv2) v2_r <= v1_r;
      if (adv3) v3_r <= v2_r;
      if (adv4) v4_r <= v3_r;
    end
  end

endmodule

// File: src/nmea_rmc_gga_sentence_parser.sv
// ============================================================================
// nmea_rmc_gga_sentence_parser: NMEA 0183 RMC/GGA sentence parser
// Byte-serial front end feeding a queue of finished sentences and a
// four-stage formatter that builds position/time and height records.
// ============================================================================
//  channel | dir | payload                          | handshake
//  in      | in  | char_byte, end_of_sentence       | valid/ready
//  out     | out | record_type .. time_packed       | valid/ready
//  cfg     | in  | zone_offset_hours                | write enable
//
// One byte is taken each cycle while the job queue has room; the parser
// state updates in that cycle. A record's job enters the queue on its final
// byte and then passes through the formatter stages to the output. Reset is
// synchronous and clears all sentence state; the zone returns to 8. A stalled
// output backs up the formatter, then the queue, then the input.
module nmea_rmc_gga_sentence_parser
  import nrgp_pkg::*;
#(
  parameter int unsigned QDepth = QueueDepth
) (
  input  logic       clk,
  input  logic       rst_n,
  nrgp_stream_if.sink   in_ch,
  nrgp_stream_if.source out_ch,
  input  logic       cfg_we,
  input  logic [4:0] cfg_wdata
);

  logic [4:0] zone_r;
  logic       in_fire, job_push, q_full, q_empty, job_pop;
  job_t       job_in, job_out;
  in_t        in_item;
  rec_t       rec;

  assign in_item   = in_ch.data;
  assign in_ch.ready = !q_full;
  assign in_fire   = in_ch.valid && !q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) zone_r <= ZoneReset;
    else if (cfg_we) zone_r <= cfg_wdata;
  end

  nrgp_parser u_parser (
    .clk, .rst_n, .in_fire, .in_item, .job_push, .job(job_in)
  );

  nrgp_queue #(.Depth(QDepth)) u_queue (
    .clk, .rst_n, .push(job_push), .push_data(job_in), .full(q_full),
    .empty(q_empty), .pop(job_pop), .pop_data(job_out)
  );

  nrgp_formatter u_fmt (
    .clk, .rst_n, .zone(zone_r), .job_valid(!q_empty), .job(job_out),
    .job_pop, .rec_valid(out_ch.valid), .rec_ready(out_ch.ready), .rec
  );

  assign out_ch.data = rec;

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    job_pop |-> !q_empty) else $error("pop from empty job queue");
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    job_push |-> !q_full) else $error("push into full job queue");
  a_gga_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && rec.record_type == REC_GGA) |-> (rec.lat_dms == '0 && rec.time_packed == '0))
    else $error("GGA record carries RMC fields");

endmodule
